@@ hw/rtl/ipdr_pkg.sv @@
// Package for the infrared pulse-distance receiver.
// Holds the status codes, register indexes, field widths and the result type.
// No dependencies.
package ipdr_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned NOM_W      = 16;
  localparam int unsigned FRAME_W    = 64;
  localparam int unsigned VENDOR_W   = 16;
  localparam int unsigned CMD_W      = 8;
  localparam int unsigned BITS_W     = 7;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned OUT_DATA_W = 96;

  localparam logic [BITS_W-1:0] SHORT_BITS = 7'd32;
  localparam logic [BITS_W-1:0] LONG_BITS  = 7'd64;

  // Reset values of the configuration registers.
  localparam logic [NOM_W-1:0] HDR_RESET  = 16'd13000;
  localparam logic [NOM_W-1:0] ONE_RESET  = 16'd1700;
  localparam logic [NOM_W-1:0] ZERO_RESET = 16'd700;
  localparam logic [NOM_W-1:0] TOL_RESET  = 16'd200;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HEADER_TIME = 3'd0,
    REG_ONE_TIME    = 3'd1,
    REG_ZERO_TIME   = 3'd2,
    REG_TOLERANCE   = 3'd3,
    REG_LONG_FRAME  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_HEADER   = 2'd0,
    STATUS_BIT      = 2'd1,
    STATUS_COMPLETE = 2'd2,
    STATUS_REJECT   = 2'd3
  } status_t;

  typedef struct packed {
    status_t               status;
    logic                  command_ok;
    logic [CMD_W-1:0]      command;
    logic [VENDOR_W-1:0]   vendor_code;
    logic [FRAME_W-1:0]    frame_data;
  } result_t;

endpackage

@@ hw/rtl/ir_pulse_distance_receiver_unit.sv @@
// Top level of the infrared pulse-distance receiver.
// The result of each accepted edge beat is registered in the result register,
// or in the skid register while a result waits. Throughput: one edge beat per
// cycle while the skid register is empty, also while a result waits.
// Reset (rst_n low, synchronous): idle, last edge time and shift register
// zero, configuration registers back to their defaults, no result pending.
// Depends on ipdr_pkg.
module ir_pulse_distance_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // Edge channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] edge_time_us
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [63:0] frame_data, [79:64] vendor_code,
                                  // [87:80] command, [88] command_ok, rest zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  // Configuration registers
  logic [ipdr_pkg::NOM_W-1:0] header_time_r;
  logic [ipdr_pkg::NOM_W-1:0] one_time_r;
  logic [ipdr_pkg::NOM_W-1:0] zero_time_r;
  logic [ipdr_pkg::NOM_W-1:0] tolerance_r;
  logic                       long_frame_r;

  // Decoder state
  logic [ipdr_pkg::TIME_W-1:0]  last_edge_r, last_edge_nxt;
  logic                         receiving_r, receiving_nxt;
  logic [ipdr_pkg::BITS_W-1:0]  bits_left_r, bits_left_nxt;
  logic [ipdr_pkg::FRAME_W-1:0] frame_shift_r, frame_shift_nxt;

  // Output buffer
  logic                  out_valid_r, out_valid_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  ipdr_pkg::result_t     out_data_r, out_data_nxt;
  ipdr_pkg::result_t     skid_data_r, skid_data_nxt;

  logic                         push;
  logic                         pop;
  logic [ipdr_pkg::TIME_W-1:0]  delta;
  logic                         hit_header, hit_one, hit_zero;
  ipdr_pkg::status_t            status;
  ipdr_pkg::result_t            result;

  // Window test: [nom - tol clamped at zero, nom + tol] with a 17-bit upper bound.
  function automatic logic in_window(input logic [ipdr_pkg::TIME_W-1:0] d,
                                     input logic [ipdr_pkg::NOM_W-1:0]  nom,
                                     input logic [ipdr_pkg::NOM_W-1:0]  tol);
    logic [ipdr_pkg::NOM_W-1:0] lo;
    logic [ipdr_pkg::NOM_W:0]   hi;
    lo = (nom > tol) ? (nom - tol) : '0;
    hi = {1'b0, nom} + {1'b0, tol};
    return (d >= {{(ipdr_pkg::TIME_W-ipdr_pkg::NOM_W){1'b0}}, lo}) &&
           (d <= {{(ipdr_pkg::TIME_W-ipdr_pkg::NOM_W-1){1'b0}}, hi});
  endfunction

  assign in_tready = !skid_valid_r;
  assign push      = in_tvalid && in_tready;
  assign pop       = out_valid_r && out_tready;

  assign delta      = in_tdata - last_edge_r;
  assign hit_header = in_window(delta, header_time_r, tolerance_r);
  assign hit_one    = in_window(delta, one_time_r, tolerance_r);
  assign hit_zero   = in_window(delta, zero_time_r, tolerance_r);

  // One decode step per accepted edge.
  always_comb begin
    last_edge_nxt   = last_edge_r;
    receiving_nxt   = receiving_r;
    bits_left_nxt   = bits_left_r;
    frame_shift_nxt = frame_shift_r;
    status          = ipdr_pkg::STATUS_REJECT;
    if (push) begin
      last_edge_nxt = in_tdata;
      if (hit_header) begin
        receiving_nxt   = 1'b1;
        bits_left_nxt   = long_frame_r ? ipdr_pkg::LONG_BITS : ipdr_pkg::SHORT_BITS;
        frame_shift_nxt = '0;
        status          = ipdr_pkg::STATUS_HEADER;
      end else if (receiving_r && (bits_left_r != '0) && (hit_one || hit_zero)) begin
        bits_left_nxt = bits_left_r - 7'd1;
        // The one window wins where the two overlap.
        frame_shift_nxt = {frame_shift_r[ipdr_pkg::FRAME_W-1:1], hit_one};
        if (bits_left_r == 7'd1) begin
          receiving_nxt = 1'b0;
          status        = ipdr_pkg::STATUS_COMPLETE;
        end else begin
          frame_shift_nxt = {frame_shift_r[ipdr_pkg::FRAME_W-2:1], hit_one, 1'b0};
          status          = ipdr_pkg::STATUS_BIT;
        end
      end else begin
        receiving_nxt = 1'b0;
        bits_left_nxt = '0;
        status        = ipdr_pkg::STATUS_REJECT;
      end
    end
  end

  always_comb begin
    result.status      = status;
    result.frame_data  = frame_shift_nxt;
    result.vendor_code = frame_shift_nxt[31:16];
    result.command     = frame_shift_nxt[7:0];
    result.command_ok  = (~frame_shift_nxt[15:8] == frame_shift_nxt[7:0]);
  end

  // Result register with a skid entry behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = result;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_time_r <= ipdr_pkg::HDR_RESET;
      one_time_r    <= ipdr_pkg::ONE_RESET;
      zero_time_r   <= ipdr_pkg::ZERO_RESET;
      tolerance_r   <= ipdr_pkg::TOL_RESET;
      long_frame_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ipdr_pkg::REG_HEADER_TIME: header_time_r <= cfg_wdata;
        ipdr_pkg::REG_ONE_TIME:    one_time_r    <= cfg_wdata;
        ipdr_pkg::REG_ZERO_TIME:   zero_time_r   <= cfg_wdata;
        ipdr_pkg::REG_TOLERANCE:   tolerance_r   <= cfg_wdata;
        ipdr_pkg::REG_LONG_FRAME:  long_frame_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r   <= '0;
      receiving_r   <= 1'b0;
      bits_left_r   <= '0;
      frame_shift_r <= '0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      last_edge_r   <= last_edge_nxt;
      receiving_r   <= receiving_nxt;
      bits_left_r   <= bits_left_nxt;
      frame_shift_r <= frame_shift_nxt;
      out_valid_r   <= out_valid_nxt;
      skid_valid_r  <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_data_r.status;
  assign out_tdata  = {7'd0, out_data_r.command_ok, out_data_r.command,
                       out_data_r.vendor_code, out_data_r.frame_data};

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the infrared pulse-distance receiver: edge timestamps are
// streamed in, each result beat is checked against a decoder kept in step here.
// Depends on ipdr_pkg and ir_pulse_distance_receiver_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned MAX_REPORTS = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;

  ir_pulse_distance_receiver_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Decoder state and configuration as seen by the checker.
  logic [ipdr_pkg::NOM_W-1:0]   hdr_us = ipdr_pkg::HDR_RESET;
  logic [ipdr_pkg::NOM_W-1:0]   one_us = ipdr_pkg::ONE_RESET;
  logic [ipdr_pkg::NOM_W-1:0]   zero_us = ipdr_pkg::ZERO_RESET;
  logic [ipdr_pkg::NOM_W-1:0]   tol_us = ipdr_pkg::TOL_RESET;
  logic                         long_mode = 1'b0;
  logic [ipdr_pkg::TIME_W-1:0]  prev_edge = '0;
  logic                         in_frame = 1'b0;
  logic [ipdr_pkg::BITS_W-1:0]  bits_to_go = '0;
  logic [ipdr_pkg::FRAME_W-1:0] shift_reg = '0;

  logic [ipdr_pkg::TIME_W-1:0] edge_times[$];
  ipdr_pkg::result_t           pending_results[$];
  logic [ipdr_pkg::TIME_W-1:0] gen_time = '0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned n_queued = 0;
  int unsigned hold_left = 0;
  logic        hold_arm = 1'b0;
  logic        hold_seen = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic in_win(logic [31:0] d, logic [15:0] nom, logic [15:0] tol);
    logic [16:0] lo;
    logic [16:0] hi;
    lo = (nom > tol) ? {1'b0, nom - tol} : 17'd0;
    hi = {1'b0, nom} + {1'b0, tol};
    return (d >= {15'd0, lo}) && (d <= {15'd0, hi});
  endfunction

  // Advances the decoder by one edge and returns the result it must produce.
  function automatic ipdr_pkg::result_t decode_edge(logic [31:0] now);
    logic [31:0]       delta;
    ipdr_pkg::status_t st;
    ipdr_pkg::result_t r;
    delta = now - prev_edge;
    prev_edge = now;
    if (in_win(delta, hdr_us, tol_us)) begin
      in_frame = 1'b1;
      bits_to_go = long_mode ? ipdr_pkg::LONG_BITS : ipdr_pkg::SHORT_BITS;
      shift_reg = '0;
      st = ipdr_pkg::STATUS_HEADER;
    end else if (in_frame && bits_to_go != '0) begin
      bits_to_go = bits_to_go - 7'd1;
      if (in_win(delta, one_us, tol_us) || in_win(delta, zero_us, tol_us)) begin
        shift_reg[0] = in_win(delta, one_us, tol_us);
        if (bits_to_go == '0) begin
          in_frame = 1'b0;
          st = ipdr_pkg::STATUS_COMPLETE;
        end else begin
          shift_reg = shift_reg << 1;
          st = ipdr_pkg::STATUS_BIT;
        end
      end else begin
        in_frame = 1'b0;
        bits_to_go = '0;
        st = ipdr_pkg::STATUS_REJECT;
      end
    end else begin
      in_frame = 1'b0;
      bits_to_go = '0;
      st = ipdr_pkg::STATUS_REJECT;
    end
    r.status = st;
    r.frame_data = shift_reg;
    r.vendor_code = shift_reg[31:16];
    r.command = shift_reg[7:0];
    r.command_ok = (~shift_reg[15:8] == shift_reg[7:0]);
    return r;
  endfunction

  // Stimulus helpers: timestamps are built from intervals on a running cursor.
  function automatic void push_abs(logic [31:0] t);
    gen_time = t;
    edge_times.push_back(t);
    n_queued++;
  endfunction

  function automatic void push_gap(logic [31:0] d);
    push_abs(gen_time + d);
  endfunction

  function automatic logic [31:0] in_window_time(logic [15:0] nom, logic [15:0] tol);
    logic [16:0] lo;
    logic [16:0] hi;
    lo = (nom > tol) ? {1'b0, nom - tol} : 17'd0;
    hi = {1'b0, nom} + {1'b0, tol};
    case ($urandom_range(3))
      0: return {15'd0, lo};
      1: return {15'd0, hi};
      default: return {15'd0, lo} + $urandom_range(hi - lo);
    endcase
  endfunction

  function automatic logic [31:0] bad_time();
    logic [31:0] d;
    d = $urandom;
    case ($urandom_range(2))
      0: d = {15'd0, {1'b0, one_us} + {1'b0, tol_us}} + 1;
      1: d = (zero_us > tol_us) ? {16'd0, zero_us - tol_us} - 1 : d;
      default: begin
        for (int k = 0; k < 20; k++) begin
          if (!in_win(d, hdr_us, tol_us) && !in_win(d, one_us, tol_us) &&
              !in_win(d, zero_us, tol_us))
            break;
          d = $urandom;
        end
      end
    endcase
    return d;
  endfunction

  // A header followed by up to nbits data intervals, MSB first; a corrupt
  // frame is cut short by one interval that fits no window.
  function automatic void queue_frame(int nbits, bit corrupt);
    logic [63:0] data;
    int          bad_at;
    data = {$urandom, $urandom};
    if ($urandom_range(1)) data[15:8] = ~data[7:0];
    bad_at = corrupt ? $urandom_range(nbits - 1) : -1;
    push_gap(in_window_time(hdr_us, tol_us));
    for (int i = nbits - 1; i >= 0; i--) begin
      if (i == bad_at) begin
        push_gap(bad_time());
        break;
      end
      push_gap(data[i] ? in_window_time(one_us, tol_us) : in_window_time(zero_us, tol_us));
    end
  endfunction

  function automatic void fill_random(int unsigned target);
    int unsigned start;
    int unsigned sel;
    start = n_queued;
    while (n_queued - start < target) begin
      sel = $urandom_range(99);
      if (sel < 65)
        queue_frame(long_mode ? 64 : 32, $urandom_range(99) < 15);
      else if (sel < 80)
        queue_frame($urandom_range(40, 1), 1'b0);
      else if (sel < 92)
        push_gap($urandom_range(1) ? $urandom : $urandom_range(70000));
      else
        push_gap(in_window_time(hdr_us, tol_us));
    end
  endfunction

  task automatic write_reg(input ipdr_pkg::reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      ipdr_pkg::REG_HEADER_TIME: hdr_us = val;
      ipdr_pkg::REG_ONE_TIME:    one_us = val;
      ipdr_pkg::REG_ZERO_TIME:   zero_us = val;
      ipdr_pkg::REG_TOLERANCE:   tol_us = val;
      ipdr_pkg::REG_LONG_FRAME:  long_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (edge_times.size() != 0 || in_tvalid || pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned idle_v, input int unsigned stall_v,
                           input logic [15:0] h, input logic [15:0] o,
                           input logic [15:0] z, input logic [15:0] t,
                           input logic lf, input int unsigned n_items);
    wait_drained();
    write_reg(ipdr_pkg::REG_HEADER_TIME, h);
    write_reg(ipdr_pkg::REG_ONE_TIME, o);
    write_reg(ipdr_pkg::REG_ZERO_TIME, z);
    write_reg(ipdr_pkg::REG_TOLERANCE, t);
    write_reg(ipdr_pkg::REG_LONG_FRAME, {15'd0, lf});
    @(posedge clk);
    cfg_we <= 1'b0;
    send_idle_pct = idle_v;
    stall_pct = stall_v;
    @(negedge clk);
    fill_random(n_items);
  endtask

  // Edge driver: a beat is offered from the queue unless the sender idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) pending_results.push_back(decode_edge(in_tdata));
      if (edge_times.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= edge_times.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started whenever hold_arm toggles.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm != hold_seen) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_arm;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  // Result monitor.
  always @(posedge clk) begin
    ipdr_pkg::result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected, status %0d data %h",
                     $realtime, out_tuser, out_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_tuser));
          check_field("frame_data", want.frame_data, out_tdata[63:0]);
          check_field("vendor_code", 64'(want.vendor_code), 64'(out_tdata[79:64]));
          check_field("command", 64'(want.command), 64'(out_tdata[87:80]));
          check_field("command_ok", 64'(want.command_ok), 64'(out_tdata[88]));
          check_field("tdata padding", 64'd0, 64'(out_tdata[95:89]));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed edges under the reset configuration.
    @(negedge clk);
    push_abs(32'hFFFF_FFFF);  // huge interval while idle
    push_abs(32'd12999);      // header reached through timestamp wrap
    push_gap(32'd1900);       // one, upper bound
    push_gap(32'd500);        // zero, lower bound
    push_gap(32'd1500);       // one, lower bound
    push_gap(32'd900);        // zero, upper bound
    push_gap(32'd901);        // just past the zero window, abort mid-frame
    push_gap(32'd12800);      // header, lower bound
    push_gap(32'd1700);
    push_gap(32'd13200);      // header upper bound restarts an open frame
    push_gap(32'd499);
    push_gap(32'd0);          // zero interval while idle
    push_abs(32'd0);
    push_gap(32'd13201);
    push_gap(32'd13000);
    push_gap(32'd1499);
    queue_frame(32, 1'b0);

    // The receiver now blocks for a long stretch while edges keep coming.
    fill_random(50);
    hold_arm <= ~hold_arm;
    fill_random(50);

    run_phase(73, 0, 16'd4500, 16'd1690, 16'd560, 16'd100, 1'b1, 110);
    // The one window touching zero gets clamped, header at the top of its range.
    run_phase(0, 73, 16'hFFFF, 16'd0, 16'd30000, 16'd400, 1'b0, 110);
    run_phase(10, 10, 16'd9000, 16'd2250, 16'd1125, 16'd0, 1'b1, 110);
    run_phase(30, 30, 16'd0, 16'hFFFF, 16'd30000, 16'hFFFF, 1'b0, 50);
    wait_drained();

    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
